// ===== src/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |=> (c)) else $error("assertion failed");
`endif

// ===== src/scf_pkg.sv =====
package scf_pkg;
  typedef struct packed {
    logic        dependent_on;
    logic [31:0] now_ms;
    logic [2:0]  weekday;
    logic [16:0] time_of_day;
  } in_word_t;
  typedef struct packed {
    logic       device_on;
    logic [3:0] write_mask;
    logic [7:0] level_white;
    logic [7:0] level_blue;
    logic [7:0] level_green;
    logic [7:0] level_red;
  } out_word_t;
  typedef enum logic [3:0] {
    ST_IDLE, ST_EVENT, ST_CHAN, ST_DIV1, ST_DIV2, ST_DONE
  } state_t;
  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_WIN0 = 3'd1;
  localparam logic [2:0] REG_WIN1 = 3'd2;
  localparam logic [2:0] REG_WIN2 = 3'd3;
  localparam logic [2:0] REG_WIN3 = 3'd4;
  localparam logic [2:0] REG_LVL0 = 3'd5;
  localparam logic [2:0] REG_LVL1 = 3'd6;
  localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;
  localparam logic [7:0] FULL_LEVEL = 8'd255;
endpackage

// ===== src/scheduled_four_channel_fader_top.sv =====
// Scheduled four-channel fader. A tick word is taken while in_ready is high, which is whenever
// the block is idle, even while the previous result word still waits in the output register.
// The block then walks the active events and, for each, the channels one by one. Each fading
// channel with a non-zero difference uses one shared restoring divider for its step interval
// and, when a step is due, again for its step level; each use holds the sequencer until done.
// Configuration is through the APB port while idle; the user must keep to this, as the block
// itself does not enforce it.
module scheduled_four_channel_fader_top #(
  parameter int NUM_CHANNELS = 4,
  parameter int NUM_EVENTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scf_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scf_pkg::out_word_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import scf_pkg::*;

  logic [15:0] ctrl;
  logic [33:0] win [4];
  logic [63:0] lvl [2];
  logic [7:0]  present [4];
  logic [7:0]  origin [4];
  logic [31:0] next_step [4];
  logic        fading;
  logic [31:0] fade_start;
  logic        on_flag;

  state_t state, state_next;
  in_word_t cur;
  logic [2:0] ev;
  logic [1:0] ch;
  logic [7:0] olev [4];
  logic [3:0] omask;
  logic [41:0] interval;

  logic        div_start, div_done;
  logic [41:0] div_a, div_q;
  logic [27:0] div_b;

  logic [2:0] reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_CTRL: prdata = {48'd0, ctrl};
      REG_WIN0: prdata = {30'd0, win[0]};
      REG_WIN1: prdata = {30'd0, win[1]};
      REG_WIN2: prdata = {30'd0, win[2]};
      REG_WIN3: prdata = {30'd0, win[3]};
      REG_LVL0: prdata = lvl[0];
      REG_LVL1: prdata = lvl[1];
      default: prdata = '0;
    endcase
  end

  // decoded control
  logic [3:0] en;
  logic [2:0] nev;
  logic       follow, suspend, day, idle_follow, ev_live;
  always_comb begin
    en = ctrl[13:10] & 4'((1 << NUM_CHANNELS) - 1);
    nev = (ctrl[9:7] > 3'(NUM_EVENTS)) ? 3'(NUM_EVENTS) : ctrl[9:7];
    follow = ctrl[14];
    suspend = ctrl[15];
    day = (cur.weekday < 3'd7) && ctrl[cur.weekday];
    idle_follow = !suspend && (ctrl[9:7] == 3'd0) && follow;
    ev_live = (ev < nev) && day;
  end

  // per event values
  logic [16:0] start_s, dur_s;
  logic [17:0] sum_s, end_s, span_s;
  logic [1:0]  evi;
  logic [7:0]  target;
  logic        in_window, at_end, at_start, zero_dur;
  logic [27:0] span_ms;
  logic [8:0]  diff;
  logic [7:0]  mag;
  logic [31:0] elapsed, since;
  logic        anyon, last_ch, step_go, step_due;
  always_comb begin
    evi = ev[1:0];
    start_s = win[evi][16:0];
    dur_s = win[evi][33:17];
    sum_s = {1'b0, start_s} + {1'b0, dur_s};
    end_s = (sum_s > {1'b0, SECONDS_PER_DAY}) ? sum_s - {1'b0, SECONDS_PER_DAY} : sum_s;
    target = lvl[evi[1]][{evi[0], ch, 3'b000} +: 8];
    in_window = ({1'b0, cur.time_of_day} >= {1'b0, start_s}) &&
                ({1'b0, cur.time_of_day} < end_s);
    at_end = {1'b0, cur.time_of_day} == end_s;
    at_start = cur.time_of_day == start_s;
    zero_dur = {1'b0, start_s} == end_s;
    span_s = end_s - {1'b0, start_s};
    span_ms = 28'(span_s) * 28'(MS_PER_SECOND);
    diff = {1'b0, target} - {1'b0, origin[ch]};
    mag = diff[8] ? 8'(-diff) : diff[7:0];
    elapsed = cur.now_ms - fade_start;
    since = cur.now_ms - next_step[ch];
    last_ch = ch == 2'(NUM_CHANNELS - 1);
    step_go = en[ch] && (mag != 8'd0);
    step_due = 42'(since) >= div_q;
    anyon = 1'b0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (present[k] != 8'd0) anyon = 1'b1;
    end
  end

  logic [41:0] num;
  always_comb begin
    // origin*span + diff*elapsed; not negative while elapsed <= span, and DIV2 drops the quotient otherwise
    num = 42'(origin[ch]) * 42'(span_ms) +
          (diff[8] ? -(42'(mag) * 42'(elapsed)) : 42'(mag) * 42'(elapsed));
  end

  scf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = suspend ? ST_DONE : ST_EVENT;
      ST_EVENT: begin
        if (!ev_live) state_next = ST_DONE;
        else if (follow) state_next = ST_EVENT;
        else if (at_start && !fading)
          state_next = (zero_dur || !in_window) ? ST_EVENT : ST_CHAN;
        else if (fading && (in_window || at_end)) state_next = ST_CHAN;
        else state_next = ST_EVENT;
      end
      ST_CHAN: begin
        if (!in_window) state_next = ST_EVENT;
        else if (step_go) state_next = ST_DIV1;
        else if (last_ch) state_next = ST_EVENT;
        else state_next = ST_CHAN;
      end
      ST_DIV1: begin
        if (div_done) begin
          if (step_due) state_next = ST_DIV2;
          else if (last_ch) state_next = ST_EVENT;
          else state_next = ST_CHAN;
        end
      end
      ST_DIV2: if (div_done) state_next = last_ch ? ST_EVENT : ST_CHAN;
      ST_DONE: if (out_ready || !out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctrl <= '0;
      for (int k = 0; k < 4; k++) begin
        win[k] <= '0;
        present[k] <= '0;
        origin[k] <= '0;
        next_step[k] <= '0;
      end
      lvl[0] <= '0;
      lvl[1] <= '0;
      fading <= 1'b0;
      fade_start <= '0;
      on_flag <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      div_start <= ((state == ST_CHAN) && (state_next == ST_DIV1)) ||
                   ((state == ST_DIV1) && (state_next == ST_DIV2));
      if (psel && penable && pwrite) begin
        if (reg_idx == REG_CTRL) ctrl <= pwdata[15:0];
        else if (reg_idx <= REG_WIN3) win[2'(reg_idx - REG_WIN0)] <= pwdata[33:0];
        else if (reg_idx == REG_LVL0) lvl[0] <= pwdata;
        else if (reg_idx == REG_LVL1) lvl[1] <= pwdata;
      end
      if ((state == ST_DONE) && (state_next == ST_IDLE)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if ((state != ST_IDLE) && (state_next == ST_EVENT)) ev <= ev + 3'd1;
      if (state == ST_EVENT) ch <= '0;
      else if (state_next == ST_CHAN) ch <= ch + 2'd1;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= in_data;
            ev <= '0;
            for (int k = 0; k < 4; k++) begin
              olev[k] <= (idle_follow && en[k] && in_data.dependent_on) ? FULL_LEVEL : 8'd0;
              omask[k] <= idle_follow && en[k];
            end
            if (idle_follow) on_flag <= in_data.dependent_on;
          end
        end
        ST_EVENT: begin
          if (ev_live && follow) begin
            for (int k = 0; k < 4; k++) begin
              if (en[k]) begin
                olev[k] <= cur.dependent_on ? FULL_LEVEL : 8'd0;
                omask[k] <= 1'b1;
              end
            end
            on_flag <= cur.dependent_on;
          end else if (ev_live) begin
            on_flag <= anyon;
            if (at_start && !fading) begin
              fade_start <= cur.now_ms;
              for (int k = 0; k < 4; k++) next_step[k] <= cur.now_ms;
              if (zero_dur) begin
                for (int k = 0; k < 4; k++) begin
                  if (en[k]) begin
                    olev[k] <= lvl[evi[1]][{evi[0], 2'(k), 3'b000} +: 8];
                    omask[k] <= 1'b1;
                  end
                end
              end else fading <= 1'b1;
            end
          end
        end
        ST_CHAN: begin
          if (in_window) begin
            if (step_go) begin
              div_a <= 42'(span_ms);
              div_b <= 28'(mag);
            end
          end else begin
            fading <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              if (en[k]) begin
                present[k] <= lvl[evi[1]][{evi[0], 2'(k), 3'b000} +: 8];
                origin[k] <= lvl[evi[1]][{evi[0], 2'(k), 3'b000} +: 8];
                olev[k] <= lvl[evi[1]][{evi[0], 2'(k), 3'b000} +: 8];
                omask[k] <= 1'b1;
              end
            end
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            interval <= div_q;
            if (step_due) begin
              div_a <= num;
              div_b <= span_ms;
            end
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            if ({10'd0, elapsed} <= 42'(span_ms)) begin
              present[ch] <= (div_q > 42'd255) ? FULL_LEVEL : div_q[7:0];
              olev[ch] <= (div_q > 42'd255) ? FULL_LEVEL : div_q[7:0];
            end else olev[ch] <= present[ch];
            omask[ch] <= 1'b1;
            next_step[ch] <= next_step[ch] + interval[31:0];
          end
        end
        ST_DONE: begin
          if (state_next == ST_IDLE) begin
            out_data.level_red <= olev[0];
            out_data.level_green <= olev[1];
            out_data.level_blue <= olev[2];
            out_data.level_white <= olev[3];
            out_data.write_mask <= omask;
            out_data.device_on <= on_flag;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/scf_divider.sv =====
// restoring divider, one quotient bit per cycle
module scf_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [41:0] dividend,
  input  logic [27:0] divisor,
  output logic        done,
  output logic [41:0] quotient
);
  logic [27:0] rem;
  logic [41:0] quo;
  logic [27:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [28:0] trial;

  assign trial = {rem, quo[41]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd42;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[28]) begin
          rem <= trial[27:0];
          quo <= {quo[40:0], 1'b1};
        end else begin
          rem <= {rem[26:0], quo[41]};
          quo <= {quo[40:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/scf_checker.sv =====
module scf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);
`include "assert_macros.svh"
  `ASSERT_IMPL(a_pready, 1'b1, pready)
  `ASSERT_NEXT(a_take_busy, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind scheduled_four_channel_fader_top scf_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pready(pready)
);
